// ----- design/met_pkg.sv -----
// Shared types, constants and helpers for the Mandelbrot escape-time core.
package met_pkg;

	localparam int FRAC_BITS = 28;
	localparam int IDX_W     = 2;
	localparam int DATA_W    = 32;
	localparam int STEP_W    = 29;
	localparam int FIELD_W   = 12;
	localparam int COUNT_W   = 8;

	localparam logic [IDX_W-1:0] REG_ORIGIN_REAL = 2'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_IMAG = 2'd1;
	localparam logic [IDX_W-1:0] REG_PIXEL_STEP  = 2'd2;

	localparam logic [63:0] FOUR_Q56 = 64'd4 << 56;

	localparam logic signed [31:0] ORIGIN_REAL_RST = -32'sd536870912;
	localparam logic signed [31:0] ORIGIN_IMAG_RST = -32'sd402653184;
	localparam logic [STEP_W-1:0]  PIXEL_STEP_RST  = 29'd805306;

	typedef struct packed {
		logic signed [63:0] rr;
		logic signed [63:0] ii;
		logic signed [63:0] ri;
	} prod_t;

	typedef struct packed {
		logic               escape;
		logic signed [31:0] nr;
		logic signed [31:0] ni;
	} step_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- design/met_cmul.sv -----
// Shared complex multiplier: three registered 32x32 signed products.
module met_cmul
	import met_pkg::*;
(
	input  logic               clk,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output prod_t              prod
);

	prod_t prod_q;

	always_ff @(posedge clk) begin
		prod_q.rr <= 64'(a_re) * 64'(b_re);
		prod_q.ii <= 64'(a_im) * 64'(b_im);
		prod_q.ri <= 64'(a_re) * 64'(b_im);
	end

	assign prod = prod_q;

endmodule

// ----- design/met_next.sv -----
// Escape test on |z|^2 and next-z formation from the registered products.
module met_next
	import met_pkg::*;
(
	input  prod_t              prod,
	input  logic signed [31:0] cr,
	input  logic signed [31:0] ci,
	output step_t              step
);

	logic [63:0]        mag;
	logic signed [63:0] diff;
	logic signed [63:0] re_sum;
	logic signed [63:0] im_sum;

	always_comb begin
		// squares are non-negative and at most 2^62
		mag    = {1'b0, prod.rr[62:0]} + {1'b0, prod.ii[62:0]};
		diff   = prod.rr - prod.ii;
		re_sum = (diff >>> FRAC_BITS) + 64'(cr);
		im_sum = (prod.ri >>> (FRAC_BITS - 1)) + 64'(ci);
		step.escape = mag > FOUR_Q56;
		step.nr     = sat32(re_sum);
		step.ni     = sat32(im_sum);
	end

endmodule

// ----- design/mandelbrot_escape_time_core.sv -----
// Top level of the Mandelbrot escape-time core: sequencer, registers and stream ports.
//
// s_tdata carries one pixel (column, row); m_tdata returns its escape count.
// A transaction on either side completes when tvalid and tready are both high.
// The pixel is mapped to c = origin + position * pixel_step on the shared
// multiplier, then z = z*z + c is iterated from z = c on the same unit.
// Each iteration runs the MUL state for the three products, then the EVAL
// state for the escape test and the z update. s_tready is high only while idle.
// The result sits in an output register, so the next pixel can be accepted
// while it waits; if the receiver still holds the previous result when a new
// one finishes, the sequencer waits until the output register frees up.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are to be made while idle; the core itself does not enforce this. Reset is
// asynchronous: it empties the core and loads origin -2.0 - 1.5i and a step
// of about 0.003.
module mandelbrot_escape_time_core
	import met_pkg::*;
#(
	parameter int ITER_LIMIT = 256,
	parameter int COORD_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // column [11:0], row [23:12]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // escape_count [7:0]
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	localparam int CB    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int CNT_W = $clog2(ITER_LIMIT + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAP  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_EVAL = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	logic [2:0]         state_q;
	logic signed [31:0] origin_re_q;
	logic signed [31:0] origin_im_q;
	logic [STEP_W-1:0]  step_q;
	logic [CB-1:0]      col_q;
	logic [CB-1:0]      row_q;
	logic signed [31:0] cr_q;
	logic signed [31:0] ci_q;
	logic signed [31:0] zr_q;
	logic signed [31:0] zi_q;
	logic [CNT_W-1:0]   count_q;
	logic [7:0]         res_q;
	logic               m_tvalid_q;
	logic [7:0]         m_tdata_q;

	logic signed [31:0] a_re;
	logic signed [31:0] a_im;
	logic signed [31:0] b_re;
	logic signed [31:0] b_im;
	prod_t              prod;
	step_t              step;
	logic               out_free;
	logic               finish;
	logic [7:0]         fin_val;
	logic [31:0]        cnt_ext;

	always_comb begin
		if (state_q == ST_MAP) begin
			a_re = 32'(col_q);
			a_im = 32'(row_q);
			b_re = 32'(step_q);
			b_im = 32'(step_q);
		end else begin
			a_re = zr_q;
			a_im = zi_q;
			b_re = zr_q;
			b_im = zi_q;
		end
	end

	met_cmul u_cmul (
		.clk  (clk),
		.a_re (a_re),
		.a_im (a_im),
		.b_re (b_re),
		.b_im (b_im),
		.prod (prod)
	);

	met_next u_next (
		.prod (prod),
		.cr   (cr_q),
		.ci   (ci_q),
		.step (step)
	);

	always_comb begin
		cnt_ext  = 32'(count_q);
		out_free = !m_tvalid_q || m_tready;
		finish   = (state_q == ST_EVAL) &&
			((count_q == CNT_W'(ITER_LIMIT)) || step.escape);
		if (count_q == CNT_W'(ITER_LIMIT))
			fin_val = 8'd0;
		else if (cnt_ext > 32'd255)
			fin_val = 8'hff;
		else
			fin_val = cnt_ext[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= ORIGIN_REAL_RST;
			origin_im_q <= ORIGIN_IMAG_RST;
			step_q      <= PIXEL_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_REAL: origin_re_q <= cfg_data;
				REG_ORIGIN_IMAG: origin_im_q <= cfg_data;
				REG_PIXEL_STEP:  step_q      <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_MAP;
				ST_MAP:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_EVAL;
				ST_EVAL: begin
					if (!finish)
						state_q <= ST_MUL;
					else if (out_free)
						state_q <= ST_IDLE;
					else
						state_q <= ST_HOLD;
				end
				ST_HOLD: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			col_q <= s_tdata[CB-1:0];
			row_q <= s_tdata[FIELD_W+CB-1:FIELD_W];
		end
		if (state_q == ST_ADD) begin
			cr_q    <= sat32(64'(origin_re_q) + prod.rr);
			ci_q    <= sat32(64'(origin_im_q) + prod.ii);
			zr_q    <= sat32(64'(origin_re_q) + prod.rr);
			zi_q    <= sat32(64'(origin_im_q) + prod.ii);
			count_q <= '0;
		end
		if (state_q == ST_EVAL && !finish) begin
			zr_q    <= step.nr;
			zi_q    <= step.ni;
			count_q <= count_q + CNT_W'(1);
		end
		if (finish)
			res_q <= fin_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((finish || state_q == ST_HOLD) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && out_free)
			m_tdata_q <= fin_val;
		else if (state_q == ST_HOLD && out_free)
			m_tdata_q <= res_q;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q[COUNT_W-1:0];

endmodule
